/* src/rhp_pkg.sv */
// ----------------------------------------------------------------------------
// RTP header parser package
// Shared types, field codes and sizing constants for the RTP header parser
// and its 16-bit audio sample extractor.
// ----------------------------------------------------------------------------
package rhp_pkg;

   localparam int unsigned MAX_PACKET_BYTES = 65535;
   localparam int unsigned POS_W = 16;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PACKET_BYTES);

   localparam int unsigned FIXED_HDR = 12;
   localparam int unsigned XH_W = 7;
   localparam int unsigned HLEN_W = 19;

   localparam logic [6:0] PT_RESET = 7'd10;
   localparam logic [1:0] HDR_VERSION = 2'd2;

   localparam int unsigned QUEUE_AW = 2;
   localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam logic [2:0] STATUS_OK = 3'd0;
   localparam logic [2:0] STATUS_BAD_FIXED = 3'd1;
   localparam logic [2:0] STATUS_SHORT_CSRC = 3'd2;
   localparam logic [2:0] STATUS_SHORT_EXT_HDR = 3'd3;
   localparam logic [2:0] STATUS_SHORT_EXT_DATA = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic               kind;
      logic signed [15:0] sample;
      logic [2:0]         status;
      logic [6:0]         payload_type;
      logic               marker;
      logic [15:0]        sequence_res;
      logic [31:0]        timestamp;
      logic [15:0]        header_bytes;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

endpackage

/* src/rhp_parse.sv */
// ----------------------------------------------------------------------------
// RTP header parser: byte decoder
// Tracks the byte position within a packet, latches the header fields,
// pairs payload bytes into samples and builds the end of packet report.
// ----------------------------------------------------------------------------
module rhp_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rhp_pkg::req_type req_data,
   input  logic [6:0]       audio_pt,
   output rhp_pkg::push_type push
);

   logic [rhp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      version_ok_ff, version_ok_in;
   logic [3:0]                csrc_ff, csrc_in;
   logic                      ext_flag_ff, ext_flag_in;
   logic [15:0]               ext_words_ff, ext_words_in;
   logic                      marker_ff, marker_in;
   logic [6:0]                pt_ff, pt_in;
   logic [15:0]               seq_ff, seq_in;
   logic [31:0]               ts_ff, ts_in;
   logic [7:0]                high_ff, high_in;
   logic                      phase_ff, phase_in;

   logic [rhp_pkg::XH_W-1:0]   xh_cur;
   logic [rhp_pkg::XH_W-1:0]   xh_new;
   logic [rhp_pkg::HLEN_W-1:0] hlen;
   logic [rhp_pkg::HLEN_W-1:0] pos_wide;
   logic [rhp_pkg::HLEN_W-1:0] size_wide;
   logic                       active;
   logic                       in_payload;
   logic                       emit_sample;
   logic [2:0]                 status;
   rhp_pkg::rsp_type           sample_rsp;
   rhp_pkg::rsp_type           report_rsp;
   logic [7:0]                 b;

   always_comb begin
      b = req_data.data_byte;
      pos_in = pos_ff;
      version_ok_in = version_ok_ff;
      csrc_in = csrc_ff;
      ext_flag_in = ext_flag_ff;
      ext_words_in = ext_words_ff;
      marker_in = marker_ff;
      pt_in = pt_ff;
      seq_in = seq_ff;
      ts_in = ts_ff;
      high_in = high_ff;
      phase_in = phase_ff;
      emit_sample = 1'b0;

      active = accept && (pos_ff != rhp_pkg::POS_LIMIT);
      xh_cur = rhp_pkg::XH_W'(rhp_pkg::FIXED_HDR) + {1'b0, csrc_ff, 2'b00};

      if (active) begin
         pos_in = pos_ff + 1'b1;
         if (pos_ff == 16'd0) begin
            version_ok_in = (b[7:6] == rhp_pkg::HDR_VERSION);
            ext_flag_in = b[4];
            csrc_in = b[3:0];
         end else if (pos_ff == 16'd1) begin
            marker_in = b[7];
            pt_in = b[6:0];
         end else if (pos_ff == 16'd2 || pos_ff == 16'd3) begin
            seq_in = {seq_ff[7:0], b};
         end else if (pos_ff >= 16'd4 && pos_ff <= 16'd7) begin
            ts_in = {ts_ff[23:0], b};
         end else if (ext_flag_ff && pos_ff == {9'd0, xh_cur} + 16'd2) begin
            ext_words_in = {b, 8'd0};
         end else if (ext_flag_ff && pos_ff == {9'd0, xh_cur} + 16'd3) begin
            ext_words_in = {ext_words_ff[15:8], b};
         end
      end

      xh_new = rhp_pkg::XH_W'(rhp_pkg::FIXED_HDR) + {1'b0, csrc_in, 2'b00};
      hlen = {12'd0, xh_new};
      if (ext_flag_in) begin
         hlen = hlen + 19'd4 + {1'b0, ext_words_in, 2'b00};
      end
      pos_wide = {3'd0, pos_ff};
      size_wide = {3'd0, pos_in};

      in_payload = active && version_ok_in && (pos_wide >= hlen) && (pt_in == audio_pt);
      if (in_payload) begin
         if (!phase_ff) begin
            high_in = b;
            phase_in = 1'b1;
         end else begin
            emit_sample = 1'b1;
            phase_in = 1'b0;
         end
      end

      if (size_wide < 19'(rhp_pkg::FIXED_HDR) || !version_ok_in) begin
         status = rhp_pkg::STATUS_BAD_FIXED;
      end else if (size_wide < {12'd0, xh_new}) begin
         status = rhp_pkg::STATUS_SHORT_CSRC;
      end else if (ext_flag_in && size_wide < {12'd0, xh_new} + 19'd4) begin
         status = rhp_pkg::STATUS_SHORT_EXT_HDR;
      end else if (ext_flag_in && size_wide < hlen) begin
         status = rhp_pkg::STATUS_SHORT_EXT_DATA;
      end else begin
         status = rhp_pkg::STATUS_OK;
      end

      sample_rsp = '0;
      sample_rsp.kind = rhp_pkg::KIND_SAMPLE;
      sample_rsp.sample = {high_ff, b};
      sample_rsp.last_result = !req_data.last_byte;

      report_rsp = '0;
      report_rsp.kind = rhp_pkg::KIND_REPORT;
      report_rsp.status = status;
      report_rsp.last_result = 1'b1;
      if (status != rhp_pkg::STATUS_BAD_FIXED) begin
         report_rsp.payload_type = pt_in;
         report_rsp.marker = marker_in;
         report_rsp.sequence_res = seq_in;
         report_rsp.timestamp = ts_in;
      end
      if (status == rhp_pkg::STATUS_OK) begin
         report_rsp.header_bytes = hlen[15:0];
      end

      push = '0;
      if (accept) begin
         if (emit_sample && req_data.last_byte) begin
            push.count = 2'd2;
            push.first = sample_rsp;
            push.second = report_rsp;
         end else if (emit_sample) begin
            push.count = 2'd1;
            push.first = sample_rsp;
         end else if (req_data.last_byte) begin
            push.count = 2'd1;
            push.first = report_rsp;
         end
      end

      if (accept && req_data.last_byte) begin
         pos_in = '0;
         version_ok_in = 1'b0;
         csrc_in = '0;
         ext_flag_in = 1'b0;
         ext_words_in = '0;
         marker_in = 1'b0;
         pt_in = '0;
         seq_in = '0;
         ts_in = '0;
         high_in = '0;
         phase_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         version_ok_ff <= 1'b0;
         csrc_ff <= '0;
         ext_flag_ff <= 1'b0;
         ext_words_ff <= '0;
         marker_ff <= 1'b0;
         pt_ff <= '0;
         seq_ff <= '0;
         ts_ff <= '0;
         high_ff <= '0;
         phase_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         version_ok_ff <= version_ok_in;
         csrc_ff <= csrc_in;
         ext_flag_ff <= ext_flag_in;
         ext_words_ff <= ext_words_in;
         marker_ff <= marker_in;
         pt_ff <= pt_in;
         seq_ff <= seq_in;
         ts_ff <= ts_in;
         high_ff <= high_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* src/rhp_result_queue.sv */
// ----------------------------------------------------------------------------
// RTP header parser: result queue
// Small register queue that takes up to two results per cycle and hands
// one result per transaction to the output channel.
// ----------------------------------------------------------------------------
module rhp_result_queue (
   input  logic              clock,
   input  logic              reset,
   input  rhp_pkg::push_type push,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rhp_pkg::rsp_type  rsp_data
);

   rhp_pkg::rsp_type                mem_ff [rhp_pkg::QUEUE_DEPTH];
   logic [rhp_pkg::QUEUE_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rhp_pkg::QUEUE_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rhp_pkg::QUEUE_AW:0]      count_ff, count_in;
   logic                            pop;

   always_comb begin
      pop = rsp_valid && rsp_ready;
      wr_ptr_in = wr_ptr_ff + rhp_pkg::QUEUE_AW'(push.count);
      rd_ptr_in = rd_ptr_ff + rhp_pkg::QUEUE_AW'(pop);
      count_in = count_ff + (rhp_pkg::QUEUE_AW + 1)'(push.count)
                 - (rhp_pkg::QUEUE_AW + 1)'(pop);
   end

   assign rsp_valid = (count_ff != '0);
   assign rsp_data = mem_ff[rd_ptr_ff];
   assign has_room = (count_ff <= (rhp_pkg::QUEUE_AW + 1)'(rhp_pkg::QUEUE_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ptr_ff + 1'b1] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (rhp_pkg::QUEUE_AW + 1)'(rhp_pkg::QUEUE_DEPTH))
      else $error("result queue count exceeds its depth");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> has_room)
      else $error("results pushed without room in the queue");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("queue count did not drop after a lone transaction");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.count == 2'd2) |-> (push.second.kind == rhp_pkg::KIND_REPORT
                                && push.first.kind == rhp_pkg::KIND_SAMPLE))
      else $error("a result pair is not a sample followed by a report");
`endif

endmodule

/* src/rtp_header_parse_audio_extract_top.sv */
// ----------------------------------------------------------------------------
// RTP header parser with audio sample extraction
// Parses RTP packets one byte per transaction and emits 16-bit samples and
// an end of packet report.
//
//   Channel  Ports                          Content
//   req      req_valid/req_ready/req_data   one packet byte and last mark
//   rsp      rsp_valid/rsp_ready/rsp_data   sample or end of packet report
//   csr      csr_valid/csr_ready/csr_data   audio payload type register
//
// A byte is decoded in the cycle it is accepted, and its results sit in a
// four-entry register queue from the next cycle on. One byte per cycle is
// accepted while the queue has two free entries; a byte that gives both a
// sample and a report needs two output transactions. Reset is synchronous; it
// clears the packet state and the queue and sets the payload type to 10.
// A stall on rsp backs the queue up and then holds req_ready low.
// ----------------------------------------------------------------------------
module rtp_header_parse_audio_extract_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rhp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rhp_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_data
);

   logic [6:0]        pt_cfg_ff, pt_cfg_in;
   logic              has_room;
   logic              accept;
   rhp_pkg::push_type push;

   assign csr_ready = 1'b1;
   assign req_ready = has_room;
   assign accept = req_valid && req_ready;

   always_comb begin
      pt_cfg_in = pt_cfg_ff;
      if (csr_valid && csr_ready) begin
         pt_cfg_in = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_cfg_ff <= rhp_pkg::PT_RESET;
      end else begin
         pt_cfg_ff <= pt_cfg_in;
      end
   end

   rhp_parse u_parse (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .audio_pt (pt_cfg_ff),
      .push     (push)
   );

   rhp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
